// ===== rtl/mfq_pkg.sv =====
// Shared types and codes of the multilevel feedback queue scheduler.
// Command, result and per-slot record layouts; no dependencies.
`default_nettype none

package mfq_pkg;

    // command item
    typedef struct packed {
        logic        opcode;
        logic [3:0]  task_id;
        logic [15:0] burst_length;
    } cmd_t;

    // result item
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  task_id_res;
        logic [31:0] time_now;
        logic        first_run;
        logic        finished;
        logic [1:0]  level;
        logic [15:0] moves;
        logic        preempted;
        logic        quantum_expired;
    } res_t;

    // per-slot task record held in the slot memory
    typedef struct packed {
        logic [15:0] remaining;
        logic [1:0]  level;
        logic [31:0] since;
        logic [15:0] moves;
        logic        started;
    } slot_rec_t;

    localparam int SLOT_REC_W = $bits(slot_rec_t);

    // opcodes
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_REFUSED  = 2'd1;
    localparam logic [1:0] ST_RAN      = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_LEVELS    = 3'd0;
    localparam logic [2:0] CFG_RR_MASK   = 3'd1;
    localparam logic [2:0] CFG_QUANTUM0  = 3'd2;
    localparam logic [2:0] CFG_QUANTUM1  = 3'd3;
    localparam logic [2:0] CFG_QUANTUM2  = 3'd4;
    localparam logic [2:0] CFG_QUANTUM3  = 3'd5;
    localparam logic [2:0] CFG_AGING     = 3'd6;

endpackage : mfq_pkg

`default_nettype wire

// ===== rtl/multilevel_feedback_queue_scheduler.sv =====
// Multilevel feedback queue scheduler with aging, top level.
// Uses mfq_pkg types and two mfq_ram instances (slot records, ready queues).
//
// An arrival (start with opcode 0) is handled in the cycle it is taken and
// busy stays low, so arrivals can follow each other every cycle. After a tick
// is taken, busy stays high through its steps: the aging walk when aging is
// enabled, level by level from the bottom up to level 1 over each waiting task;
// the preemption check and write-back; the pick when no task runs; and the
// read-modify-write of the running task's record, unless nothing waits. Tick
// length is set by the serial walk through the ready-queue memory (one read,
// one write port) and the read-modify-write of the slot record memory. Every
// item gives one result on result for one cycle marked by result_valid, in the
// first cycle that busy is low again; the receiver cannot stall it, so it must
// take each transfer when it appears. cfg_ready is always high; the user must
// write registers only while busy is low and no result is pending, as the
// block does not enforce it. No clearing pass runs after reset.
`default_nettype none

module multilevel_feedback_queue_scheduler
    import mfq_pkg::*;
#(
    parameter int MAX_TASKS  = 16,
    parameter int NUM_LEVELS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire cmd_t        cmd,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             result_valid,
    output res_t             result
);

    localparam int SW  = $clog2(MAX_TASKS);
    localparam int LW  = $clog2(MAX_TASKS + 1);
    localparam int LVB = $clog2(NUM_LEVELS);
    localparam int OD  = NUM_LEVELS * MAX_TASKS;
    localparam int OAW = $clog2(OD);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_AGE_RD    = 4'd1;
    localparam logic [3:0] S_AGE_SLOT  = 4'd2;
    localparam logic [3:0] S_AGE_CHK   = 4'd3;
    localparam logic [3:0] S_PRE       = 4'd4;
    localparam logic [3:0] S_PRE_WR    = 4'd5;
    localparam logic [3:0] S_PICK      = 4'd6;
    localparam logic [3:0] S_PICK_WAIT = 4'd7;
    localparam logic [3:0] S_RUN_RD    = 4'd8;
    localparam logic [3:0] S_RUN_EX    = 4'd9;

    // configuration registers
    logic [2:0]  levels_reg;
    logic [3:0]  rr_mask_reg;
    logic [7:0]  quantum_reg [4];
    logic [15:0] aging_reg;

    // scheduler state
    logic [3:0]     state_reg, state_next;
    logic [31:0]    time_reg, time_next;
    logic [MAX_TASKS-1:0] slot_busy_reg, slot_busy_next;
    logic [LW-1:0]  len_reg [NUM_LEVELS];
    logic [LW-1:0]  len_next [NUM_LEVELS];
    logic [SW-1:0]  head_reg [NUM_LEVELS];
    logic [SW-1:0]  head_next [NUM_LEVELS];
    logic           run_valid_reg, run_valid_next;
    logic [SW-1:0]  run_slot_reg, run_slot_next;
    logic [1:0]     run_level_reg, run_level_next;
    logic [7:0]     qused_reg, qused_next;
    logic           pre_reg, pre_next;
    logic [LVB-1:0] age_lv_reg, age_lv_next;
    logic [LW-1:0]  rd_pos_reg, rd_pos_next;
    logic [LW-1:0]  wr_pos_reg, wr_pos_next;
    logic [SW-1:0]  cur_slot_reg, cur_slot_next;
    logic           res_valid_reg, res_valid_next;
    res_t           res_reg, res_next;

    // memory ports
    logic                  sram_we;
    logic [SW-1:0]         sram_waddr, sram_raddr;
    logic [SLOT_REC_W-1:0] sram_wdata, sram_rdata;
    logic                  oram_we;
    logic [OAW-1:0]        oram_waddr, oram_raddr;
    logic [SW-1:0]         oram_wdata, oram_rdata;

    // working values
    slot_rec_t      rec_rd, rec_wr;
    logic [2:0]     act_levels;
    logic [SW-1:0]  arr_slot;
    logic           arr_refused;
    logic           aged;
    logic           pre_hit;
    logic           pick_found;
    logic [LVB-1:0] pick_lv;
    logic [LVB-1:0] lv_up;
    logic [LVB-1:0] rl_idx;
    logic [SW-1:0]  new_head;
    logic [7:0]     qused_inc;
    logic [7:0]     quantum_sel;
    logic [2:0]     nl_wide;
    logic [1:0]     nl;
    logic           fin;
    logic           expd;

    assign rec_rd    = slot_rec_t'(sram_rdata);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign arr_slot     = SW'(cmd.task_id);
    assign arr_refused  = (32'(cmd.task_id) >= MAX_TASKS) || slot_busy_reg[arr_slot];

    // effective number of levels
    assign act_levels = (levels_reg == 3'd0) ? 3'd1 :
                        (levels_reg > 3'(NUM_LEVELS)) ? 3'(NUM_LEVELS) : levels_reg;

    // circular position inside a level's queue
    function automatic logic [SW-1:0] pos_f(input logic [SW-1:0] h, input logic [LW-1:0] off);
        logic [SW:0] s;
        s = (SW+1)'(h) + (SW+1)'(off);
        if (s >= (SW+1)'(MAX_TASKS))
        begin
            s = s - (SW+1)'(MAX_TASKS);
        end
        return SW'(s);
    endfunction

    // queue memory address of one level's position
    function automatic logic [OAW-1:0] oaddr_f(input logic [LVB-1:0] lv, input logic [SW-1:0] p);
        return OAW'(lv) * OAW'(MAX_TASKS) + OAW'(p);
    endfunction

    mfq_ram #(
        .WIDTH (SLOT_REC_W),
        .DEPTH (MAX_TASKS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    mfq_ram #(
        .WIDTH (SW),
        .DEPTH (OD)
    ) u_queue_ram (
        .clk   (clk),
        .we    (oram_we),
        .waddr (oram_waddr),
        .wdata (oram_wdata),
        .raddr (oram_raddr),
        .rdata (oram_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg     <= 3'd3;
            rr_mask_reg    <= 4'd3;
            quantum_reg[0] <= 8'd2;
            quantum_reg[1] <= 8'd4;
            quantum_reg[2] <= 8'd8;
            quantum_reg[3] <= 8'd16;
            aging_reg      <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEVELS:   levels_reg     <= cfg_data[2:0];
                CFG_RR_MASK:  rr_mask_reg    <= cfg_data[3:0];
                CFG_QUANTUM0: quantum_reg[0] <= cfg_data[7:0];
                CFG_QUANTUM1: quantum_reg[1] <= cfg_data[7:0];
                CFG_QUANTUM2: quantum_reg[2] <= cfg_data[7:0];
                CFG_QUANTUM3: quantum_reg[3] <= cfg_data[7:0];
                CFG_AGING:    aging_reg      <= cfg_data;
                default:      ;
            endcase
        end
    end

    // preemption check and pick search over the level lengths
    always_comb
    begin
        pre_hit    = 1'b0;
        pick_found = 1'b0;
        pick_lv    = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if ((2'(l) < run_level_reg) && (len_reg[l] != '0))
            begin
                pre_hit = 1'b1;
            end
        end
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (len_reg[l] != '0)
            begin
                pick_found = 1'b1;
                pick_lv    = LVB'(l);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        slot_busy_next = slot_busy_reg;
        len_next       = len_reg;
        head_next      = head_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        run_level_next = run_level_reg;
        qused_next     = qused_reg;
        pre_next       = pre_reg;
        age_lv_next    = age_lv_reg;
        rd_pos_next    = rd_pos_reg;
        wr_pos_next    = wr_pos_reg;
        cur_slot_next  = cur_slot_reg;
        res_valid_next = 1'b0;
        res_next       = '0;
        sram_we        = 1'b0;
        sram_waddr     = '0;
        sram_wdata     = '0;
        sram_raddr     = '0;
        oram_we        = 1'b0;
        oram_waddr     = '0;
        oram_wdata     = '0;
        oram_raddr     = '0;
        rec_wr         = rec_rd;
        aged           = 1'b0;
        lv_up          = age_lv_reg - LVB'(1);
        rl_idx         = LVB'(run_level_reg);
        new_head       = '0;
        qused_inc      = qused_reg + 8'd1;
        quantum_sel    = quantum_reg[rec_rd.level];
        nl_wide        = 3'({1'b0, rec_rd.level}) + 3'd1;
        if (nl_wide > act_levels - 3'd1)
        begin
            nl_wide = act_levels - 3'd1;
        end
        nl   = 2'(nl_wide);
        fin  = 1'b0;
        expd = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.opcode == OP_ARRIVE)
                    begin
                        // arrival handled at once
                        res_valid_next       = 1'b1;
                        res_next.task_id_res = cmd.task_id;
                        res_next.time_now    = time_reg;
                        if (arr_refused)
                        begin
                            res_next.status = ST_REFUSED;
                        end
                        else
                        begin
                            res_next.status         = ST_ACCEPTED;
                            slot_busy_next[arr_slot] = 1'b1;
                            rec_wr.remaining = cmd.burst_length;
                            rec_wr.level     = 2'd0;
                            rec_wr.since     = time_reg;
                            rec_wr.moves     = 16'd0;
                            rec_wr.started   = 1'b0;
                            sram_we    = 1'b1;
                            sram_waddr = arr_slot;
                            sram_wdata = rec_wr;
                            oram_we    = 1'b1;
                            oram_waddr = oaddr_f('0, pos_f(head_reg[0], len_reg[0]));
                            oram_wdata = arr_slot;
                            len_next[0] = len_reg[0] + LW'(1);
                        end
                    end
                    else
                    begin
                        pre_next = 1'b0;
                        if (aging_reg != 16'd0)
                        begin
                            age_lv_next = LVB'(NUM_LEVELS - 1);
                            rd_pos_next = '0;
                            wr_pos_next = '0;
                            state_next  = S_AGE_RD;
                        end
                        else
                        begin
                            state_next = S_PRE;
                        end
                    end
                end
            end

            S_AGE_RD:
            begin
                // walk one level's queue, compacting in place
                if (rd_pos_reg == len_reg[age_lv_reg])
                begin
                    len_next[age_lv_reg] = wr_pos_reg;
                    rd_pos_next = '0;
                    wr_pos_next = '0;
                    if (age_lv_reg == LVB'(1))
                    begin
                        state_next = S_PRE;
                    end
                    else
                    begin
                        age_lv_next = lv_up;
                    end
                end
                else
                begin
                    oram_raddr = oaddr_f(age_lv_reg, pos_f(head_reg[age_lv_reg], rd_pos_reg));
                    state_next = S_AGE_SLOT;
                end
            end

            S_AGE_SLOT:
            begin
                cur_slot_next = oram_rdata;
                sram_raddr    = oram_rdata;
                state_next    = S_AGE_CHK;
            end

            S_AGE_CHK:
            begin
                aged = ((time_reg - rec_rd.since) >= {16'd0, aging_reg});
                oram_we    = 1'b1;
                oram_wdata = cur_slot_reg;
                if (aged)
                begin
                    // promote to the back of the level above
                    rec_wr.level = 2'(lv_up);
                    rec_wr.since = time_reg;
                    if (rec_rd.moves != 16'hFFFF)
                    begin
                        rec_wr.moves = rec_rd.moves + 16'd1;
                    end
                    sram_we    = 1'b1;
                    sram_waddr = cur_slot_reg;
                    sram_wdata = rec_wr;
                    oram_waddr = oaddr_f(lv_up, pos_f(head_reg[lv_up], len_reg[lv_up]));
                    len_next[lv_up] = len_reg[lv_up] + LW'(1);
                end
                else
                begin
                    oram_waddr  = oaddr_f(age_lv_reg, pos_f(head_reg[age_lv_reg], wr_pos_reg));
                    wr_pos_next = wr_pos_reg + LW'(1);
                end
                rd_pos_next = rd_pos_reg + LW'(1);
                state_next  = S_AGE_RD;
            end

            S_PRE:
            begin
                if (run_valid_reg && pre_hit)
                begin
                    sram_raddr = run_slot_reg;
                    state_next = S_PRE_WR;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end

            S_PRE_WR:
            begin
                // running task back to the front of its level
                new_head = (head_reg[rl_idx] == '0) ? SW'(MAX_TASKS - 1)
                                                    : head_reg[rl_idx] - SW'(1);
                rec_wr.since = time_reg;
                sram_we    = 1'b1;
                sram_waddr = run_slot_reg;
                sram_wdata = rec_wr;
                oram_we    = 1'b1;
                oram_waddr = oaddr_f(rl_idx, new_head);
                oram_wdata = run_slot_reg;
                head_next[rl_idx] = new_head;
                len_next[rl_idx]  = len_reg[rl_idx] + LW'(1);
                run_valid_next = 1'b0;
                qused_next     = 8'd0;
                pre_next       = 1'b1;
                state_next     = S_PICK;
            end

            S_PICK:
            begin
                if (run_valid_reg)
                begin
                    state_next = S_RUN_RD;
                end
                else if (pick_found)
                begin
                    oram_raddr = oaddr_f(pick_lv, head_reg[pick_lv]);
                    head_next[pick_lv] = pos_f(head_reg[pick_lv], LW'(1));
                    len_next[pick_lv]  = len_reg[pick_lv] - LW'(1);
                    state_next = S_PICK_WAIT;
                end
                else
                begin
                    // nothing waiting
                    time_next          = time_reg + 32'd1;
                    res_valid_next     = 1'b1;
                    res_next.status    = ST_IDLE;
                    res_next.time_now  = time_reg + 32'd1;
                    res_next.preempted = pre_reg;
                    state_next         = S_IDLE;
                end
            end

            S_PICK_WAIT:
            begin
                run_slot_next  = oram_rdata;
                run_valid_next = 1'b1;
                qused_next     = 8'd0;
                state_next     = S_RUN_RD;
            end

            S_RUN_RD:
            begin
                sram_raddr = run_slot_reg;
                state_next = S_RUN_EX;
            end

            S_RUN_EX:
            begin
                // one unit of work, then completion or quantum expiry
                run_level_next = rec_rd.level;
                rec_wr.started = 1'b1;
                time_next      = time_reg + 32'd1;
                if (rec_rd.remaining <= 16'd1)
                begin
                    fin = 1'b1;
                    rec_wr.remaining = 16'd0;
                    slot_busy_next[run_slot_reg] = 1'b0;
                    run_valid_next = 1'b0;
                    qused_next     = 8'd0;
                end
                else
                begin
                    rec_wr.remaining = rec_rd.remaining - 16'd1;
                    if (rr_mask_reg[rec_rd.level])
                    begin
                        qused_next = qused_inc;
                        if ((quantum_sel != 8'd0) && (qused_inc == quantum_sel))
                        begin
                            expd = 1'b1;
                            if (nl != rec_rd.level)
                            begin
                                rec_wr.level = nl;
                                if (rec_rd.moves != 16'hFFFF)
                                begin
                                    rec_wr.moves = rec_rd.moves + 16'd1;
                                end
                            end
                            rec_wr.since = time_reg + 32'd1;
                            oram_we    = 1'b1;
                            oram_waddr = oaddr_f(LVB'(nl),
                                                 pos_f(head_reg[LVB'(nl)], len_reg[LVB'(nl)]));
                            oram_wdata = run_slot_reg;
                            len_next[LVB'(nl)] = len_reg[LVB'(nl)] + LW'(1);
                            run_valid_next = 1'b0;
                            qused_next     = 8'd0;
                        end
                    end
                end
                sram_we    = 1'b1;
                sram_waddr = run_slot_reg;
                sram_wdata = rec_wr;
                res_valid_next           = 1'b1;
                res_next.status          = ST_RAN;
                res_next.task_id_res     = 4'(run_slot_reg);
                res_next.time_now        = time_reg + 32'd1;
                res_next.first_run       = ~rec_rd.started;
                res_next.finished        = fin;
                res_next.level           = rec_wr.level;
                res_next.moves           = rec_wr.moves;
                res_next.preempted       = pre_reg;
                res_next.quantum_expired = expd;
                state_next               = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= 32'd0;
            slot_busy_reg <= '0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                len_reg[l]  <= '0;
                head_reg[l] <= '0;
            end
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            run_level_reg <= 2'd0;
            qused_reg     <= 8'd0;
            pre_reg       <= 1'b0;
            age_lv_reg    <= '0;
            rd_pos_reg    <= '0;
            wr_pos_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            slot_busy_reg <= slot_busy_next;
            len_reg       <= len_next;
            head_reg      <= head_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            run_level_reg <= run_level_next;
            qused_reg     <= qused_next;
            pre_reg       <= pre_next;
            age_lv_reg    <= age_lv_next;
            rd_pos_reg    <= rd_pos_next;
            wr_pos_reg    <= wr_pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_slot_reg <= cur_slot_next;
        res_reg      <= res_next;
    end

endmodule : multilevel_feedback_queue_scheduler

`default_nettype wire

// ===== rtl/mfq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic storage used for the slot records and the ready queues; no dependencies.
`default_nettype none

module mfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : mfq_ram

`default_nettype wire
